// ----- rtl/ddt_pkg.sv -----
package ddt_pkg;

    localparam int Q_W    = 32;
    localparam int DIFF_W = Q_W + 1;
    localparam int FRAC_W = 16;
    localparam int NUM_W  = DIFF_W + FRAC_W;
    localparam int PT_W   = 4;
    localparam int TAG_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;

    localparam logic [Q_W-1:0] Q_MAX_VAL = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN_VAL = 32'h8000_0000;

    typedef struct packed {
        logic signed [Q_W-1:0] x_value;
        logic signed [Q_W-1:0] y_value;
    } in_t;

    typedef struct packed {
        logic [TAG_W-1:0]      diff_order;
        logic [TAG_W-1:0]      entry_index;
        logic signed [Q_W-1:0] entry_value;
        logic                  zero_divisor;
        logic                  saturated;
        logic                  last_entry;
    } out_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_CALC,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             load_we;
        logic [PT_W-1:0]  wr_addr;
        logic [PT_W-1:0]  rd_addr0;
        logic [PT_W-1:0]  col_addr1;
        logic [PT_W-1:0]  abs_addr1;
        logic             calc;
        logic             emit;
        logic             divided;
        logic [TAG_W-1:0] tag_order;
        logic [TAG_W-1:0] tag_index;
        logic             tag_last;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/ddt_ram.sv -----
module ddt_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 8
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr_a,
        input  logic [$clog2(DEPTH)-1:0] raddr_b,
        output logic [WIDTH-1:0]         rdata_a,
        output logic [WIDTH-1:0]         rdata_b
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

// ----- rtl/ddt_divider.sv -----
module ddt_divider
    import ddt_pkg::*;
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              start,
        input  logic [NUM_W-1:0]  dividend,
        input  logic [DIFF_W-1:0] divisor,
        output logic [NUM_W-1:0]  quotient,
        output logic              done
    );

    localparam int CW = $clog2(NUM_W);

    logic [DIFF_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DIFF_W-1:0] den_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIFF_W:0]   shifted;
    logic [DIFF_W+1:0] trial;
    logic              ge;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        ge        = ~trial[DIFF_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[DIFF_W-1:0] : shifted[DIFF_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/ddt_datapath.sv -----
module ddt_datapath
    import ddt_pkg::*;
    #(
        parameter int MAX_POINTS = 8
    )
    (
        input  logic    clk,
        input  logic    rst_n,
        input  in_t     in_data,
        input  cmd_t    cmd,
        output status_t status,
        output logic    out_valid,
        input  logic    out_stall,
        output out_t    out_data
    );

    localparam int IW = $clog2(MAX_POINTS);

    logic [Q_W-1:0]    col_rd0, col_rd1, abs_rd0, abs_rd1;
    logic [Q_W-1:0]    col_wdata;
    logic              col_we;
    logic [DIFF_W-1:0] diff, den, diff_mag, den_mag;
    logic              need_div;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  quo;
    logic              neg_reg;
    logic [Q_W-1:0]    direct_val, quo_val;
    logic              direct_sat, quo_sat;
    logic [Q_W-1:0]    res_val_reg;
    logic              res_sat_reg, res_zdiv_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;
    logic              out_free;

    assign col_we    = cmd.load_we | cmd.emit;
    assign col_wdata = cmd.load_we ? in_data.y_value : res_val_reg;

    ddt_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_column_store (
        .clk     (clk),
        .we      (col_we),
        .waddr   (cmd.wr_addr[IW-1:0]),
        .wdata   (col_wdata),
        .raddr_a (cmd.rd_addr0[IW-1:0]),
        .raddr_b (cmd.col_addr1[IW-1:0]),
        .rdata_a (col_rd0),
        .rdata_b (col_rd1)
    );

    ddt_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_abscissa_store (
        .clk     (clk),
        .we      (cmd.load_we),
        .waddr   (cmd.wr_addr[IW-1:0]),
        .wdata   (in_data.x_value),
        .raddr_a (cmd.rd_addr0[IW-1:0]),
        .raddr_b (cmd.abs_addr1[IW-1:0]),
        .rdata_a (abs_rd0),
        .rdata_b (abs_rd1)
    );

    always_comb
    begin
        diff     = {col_rd1[Q_W-1], col_rd1} - {col_rd0[Q_W-1], col_rd0};
        den      = {abs_rd1[Q_W-1], abs_rd1} - {abs_rd0[Q_W-1], abs_rd0};
        diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        den_mag  = den[DIFF_W-1] ? (~den + 1'b1) : den;
        need_div = cmd.divided && (den != '0);
        div_start = cmd.calc && need_div;

        // plain difference clamp, or zero when the spacing vanished
        direct_sat = 1'b0;
        direct_val = '0;
        if (!cmd.divided)
        begin
            direct_sat = diff[DIFF_W-1] != diff[Q_W-1];
            if (direct_sat)
            begin
                direct_val = diff[DIFF_W-1] ? Q_MIN_VAL : Q_MAX_VAL;
            end
            else
            begin
                direct_val = diff[Q_W-1:0];
            end
        end

        // quotient magnitude back to signed with clamp
        if (!neg_reg)
        begin
            quo_sat = quo[NUM_W-1:Q_W-1] != '0;
            quo_val = quo_sat ? Q_MAX_VAL : quo[Q_W-1:0];
        end
        else
        begin
            quo_sat = (quo[NUM_W-1:Q_W] != '0) || (quo[Q_W-1] && (quo[Q_W-2:0] != '0));
            quo_val = quo_sat ? Q_MIN_VAL : (~quo[Q_W-1:0] + 1'b1);
        end
    end

    ddt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({diff_mag, {FRAC_W{1'b0}}}),
        .divisor  (den_mag),
        .quotient (quo),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            neg_reg <= diff[DIFF_W-1] ^ den[DIFF_W-1];
        end
        if (cmd.calc && !need_div)
        begin
            res_val_reg  <= direct_val;
            res_sat_reg  <= direct_sat;
            res_zdiv_reg <= cmd.divided;
        end
        else if (div_done)
        begin
            res_val_reg  <= quo_val;
            res_sat_reg  <= quo_sat;
            res_zdiv_reg <= 1'b0;
        end
        if (cmd.emit)
        begin
            out_data_reg.diff_order   <= cmd.tag_order;
            out_data_reg.entry_index  <= cmd.tag_index;
            out_data_reg.entry_value  <= res_val_reg;
            out_data_reg.zero_divisor <= res_zdiv_reg;
            out_data_reg.saturated    <= res_sat_reg;
            out_data_reg.last_entry   <= cmd.tag_last;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.need_div = need_div;
    assign status.div_done = div_done;
    assign status.out_free = out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/ddt_controller.sv -----
module ddt_controller
    import ddt_pkg::*;
    #(
        parameter int MAX_POINTS = 8
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        input  logic                  in_valid,
        output logic                  in_stall,
        input  logic                  cfg_valid,
        output logic                  cfg_ready,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data,
        input  status_t               status,
        output cmd_t                  cmd
    );

    state_t          state_reg, state_next;
    logic            mode_reg;
    logic [PT_W-1:0] count_reg;
    logic [PT_W-1:0] loaded_reg, loaded_next;
    logic [PT_W-1:0] order_reg, order_next;
    logic [PT_W-1:0] j_reg, j_next;
    logic [PT_W-1:0] n_eff;
    logic [PT_W-1:0] load_idx;
    logic            in_xfer;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            count_reg <= 4'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TABLE_MODE:  mode_reg  <= cfg_data[0];
                REG_POINT_COUNT: count_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (count_reg < PT_W'(2))
        begin
            n_eff = PT_W'(2);
        end
        else if (count_reg > PT_W'(MAX_POINTS))
        begin
            n_eff = PT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            loaded_reg <= '0;
            order_reg  <= '0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            order_reg  <= order_next;
            j_reg      <= j_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        order_next  = order_reg;
        j_next      = j_reg;
        in_stall    = 1'b1;
        in_xfer     = 1'b0;
        // a lowered count restarts the set
        load_idx    = (loaded_reg >= n_eff) ? '0 : loaded_reg;

        cmd.load_we   = 1'b0;
        cmd.wr_addr   = j_reg;
        cmd.rd_addr0  = j_reg;
        cmd.col_addr1 = j_reg + 1'b1;
        cmd.abs_addr1 = j_reg + order_reg;
        cmd.calc      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.divided   = mode_reg;
        cmd.tag_order = order_reg[TAG_W-1:0];
        cmd.tag_index = j_reg[TAG_W-1:0];
        cmd.tag_last  = order_reg == (n_eff - 1'b1);

        case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                in_xfer  = in_valid;
                cmd.wr_addr = load_idx;
                cmd.load_we = in_xfer;
                if (in_xfer)
                begin
                    if (load_idx + 1'b1 == n_eff)
                    begin
                        loaded_next = '0;
                        order_next  = PT_W'(1);
                        j_next      = '0;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        loaded_next = load_idx + 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = status.need_div ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    // walk the column, then move up one order
                    if (j_reg + order_reg + 1'b1 < n_eff)
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_READ;
                    end
                    else if (order_reg + 1'b1 < n_eff)
                    begin
                        order_next = order_reg + 1'b1;
                        j_next     = '0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/divided_difference_table.sv -----
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_data  (x_value, y_value)
// out      output     out_valid/out_stall out_data (order, index, value, flags)
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a point that does not close a set is taken without stall; the closing point starts the table
// each entry passes through read, compute and emit in forward mode, and through read, compute, divide
// and emit in divided mode, the divide using the one-bit-per-cycle 49-bit divider; a zero spacing skips the divide;
// n points give n*(n-1)/2 entries
// reset clears control and configuration only; the point stores hold no reset value
// a stalled output holds in its register; the table walk waits in the emit state
module divided_difference_table
    import ddt_pkg::*;
    #(
        parameter int MAX_POINTS = 8
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        input  logic                  in_valid,
        output logic                  in_stall,
        input  in_t                   in_data,
        output logic                  out_valid,
        input  logic                  out_stall,
        output out_t                  out_data,
        input  logic                  cfg_valid,
        output logic                  cfg_ready,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data
    );

    cmd_t    cmd;
    status_t status;

    ddt_controller #(.MAX_POINTS(MAX_POINTS)) u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    ddt_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
